// File: hdl/spi_frame_checker_link_monitor_defines.svh
// Assertion macros shared by the frame checker and link monitor modules.
`ifndef SPI_FRAME_CHECKER_LINK_MONITOR_DEFINES_SVH
`define SPI_FRAME_CHECKER_LINK_MONITOR_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define SFC_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("sfc assertion failed");

// Next-cycle implication, checked on clk_i outside reset.
`define SFC_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("sfc assertion failed");

`endif

// File: hdl/sfc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the frame checker.
package sfc_pkg;

  // CRC-16/CCITT-FALSE
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // header bytes kept: 0..6
  localparam int unsigned HDR_COUNT = 7;

  // verdict codes
  localparam logic [1:0] VERDICT_GOOD   = 2'd0;
  localparam logic [1:0] VERDICT_MAGIC  = 2'd1;
  localparam logic [1:0] VERDICT_LENGTH = 2'd2;
  localparam logic [1:0] VERDICT_CRC    = 2'd3;

  // link states
  localparam logic [1:0] LINK_DOWN     = 2'd0;
  localparam logic [1:0] LINK_DEGRADED = 2'd1;
  localparam logic [1:0] LINK_OK       = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MAGIC_WORD     = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_LIMIT  = 2'd1;
  localparam logic [1:0] REG_DOWN_THRESHOLD = 2'd2;

  // outcome of one frame, valid in the cycle its final byte is processed
  typedef struct packed {
    logic       done;
    logic [1:0] verdict;
    logic [7:0] message_id;
    logic [7:0] message_flags;
    logic [7:0] payload_length;
  } chk_t;

  // link health after a frame
  typedef struct packed {
    logic [1:0] link_state;
    logic       not_responding;
    logic [7:0] bad_run;
  } health_t;

  // one byte of CRC, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/sfc_frame_check.sv
// Byte position, running CRC, header capture and per-frame verdict.
module sfc_frame_check #(
  parameter int FRAME_BYTES = 32,
  parameter int CRC_OFFSET  = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       magic_word_i,
  input  logic [7:0]        payload_limit_i,
  output logic              last_o,
  output sfc_pkg::chk_t     chk_o
);
  import sfc_pkg::*;

  localparam int PosW = $clog2(FRAME_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_BYTES - 1);
  // CRC bytes may lie partly or wholly past the frame end
  localparam bit CrcLoIn = (CRC_OFFSET < FRAME_BYTES);
  localparam bit CrcHiIn = (CRC_OFFSET + 1 < FRAME_BYTES);
  localparam logic [PosW-1:0] CrcLoPos = CrcLoIn ? PosW'(CRC_OFFSET) : '0;
  localparam logic [PosW-1:0] CrcHiPos = CrcHiIn ? PosW'(CRC_OFFSET + 1) : '0;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d, crc_next;
  logic [7:0]      rcv_lo_q, rcv_lo_d, rcv_hi_q, rcv_hi_d;
  logic [7:0]      hdr_q [HDR_COUNT];
  logic            in_crc_span;
  logic [1:0]      verdict;

  assign last_o = (pos_q == LastPos);

  // bytes below the CRC offset feed the CRC
  assign in_crc_span = CrcLoIn ? (pos_q < CrcLoPos) : 1'b1;
  assign crc_next    = in_crc_span ? crc16_byte(crc_q, byte_i) : crc_q;

  // received CRC bytes, cleared at frame start
  always_comb begin
    rcv_lo_d = rcv_lo_q;
    rcv_hi_d = rcv_hi_q;
    if (pos_q == '0) begin
      rcv_lo_d = '0;
      rcv_hi_d = '0;
    end
    if (CrcLoIn && pos_q == CrcLoPos) begin
      rcv_lo_d = byte_i;
    end
    if (CrcHiIn && pos_q == CrcHiPos) begin
      rcv_hi_d = byte_i;
    end
  end

  // advance position and CRC
  assign pos_d = last_o ? '0 : pos_q + 1'b1;
  assign crc_d = last_o ? CRC_INIT : crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
    end else if (step_i) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // capture header and CRC bytes
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rcv_lo_q <= rcv_lo_d;
      rcv_hi_q <= rcv_hi_d;
      if (pos_q < PosW'(HDR_COUNT)) begin
        hdr_q[pos_q[2:0]] <= byte_i;
      end
    end
  end

  // checks in priority order: magic, length, CRC
  always_comb begin
    if ({hdr_q[1], hdr_q[0]} != magic_word_i) begin
      verdict = VERDICT_MAGIC;
    end else if (hdr_q[6] > payload_limit_i) begin
      verdict = VERDICT_LENGTH;
    end else if ({rcv_hi_d, rcv_lo_d} != crc_next) begin
      verdict = VERDICT_CRC;
    end else begin
      verdict = VERDICT_GOOD;
    end
  end

  assign chk_o.done           = step_i && last_o;
  assign chk_o.verdict        = verdict;
  assign chk_o.message_id     = (verdict == VERDICT_GOOD) ? hdr_q[4] : 8'h00;
  assign chk_o.message_flags  = (verdict == VERDICT_GOOD) ? hdr_q[5] : 8'h00;
  assign chk_o.payload_length = hdr_q[6];

endmodule

// File: hdl/sfc_link_health.sv
// Bad-frame streak, link state and not-responding flag.
module sfc_link_health (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sfc_pkg::chk_t    chk_i,
  input  logic [7:0]       down_threshold_i,
  output sfc_pkg::health_t health_o
);
  import sfc_pkg::*;

  `include "spi_frame_checker_link_monitor_defines.svh"

  logic [7:0] streak_q, streak_d;
  logic [1:0] link_q, link_d;
  logic       silent_q, silent_d;

  // next health from this frame's verdict
  always_comb begin
    streak_d = streak_q;
    link_d   = link_q;
    silent_d = silent_q;
    if (chk_i.verdict == VERDICT_GOOD) begin
      streak_d = '0;
      silent_d = 1'b0;
      link_d   = LINK_OK;
    end else begin
      if (streak_q != 8'hFF) begin
        streak_d = streak_q + 8'd1;
      end
      if (streak_d >= down_threshold_i) begin
        link_d   = LINK_DOWN;
        silent_d = 1'b1;
      end else if (link_q == LINK_OK) begin
        link_d = LINK_DEGRADED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      streak_q <= '0;
      link_q   <= LINK_DOWN;
      silent_q <= 1'b0;
    end else if (chk_i.done) begin
      streak_q <= streak_d;
      link_q   <= link_d;
      silent_q <= silent_d;
    end
  end

  assign health_o.link_state     = link_d;
  assign health_o.not_responding = silent_d;
  assign health_o.bad_run        = streak_d;

  // an OK link has no outstanding bad frames
  `SFC_ASSERT_IMP(a_ok_no_streak, link_q == LINK_OK, streak_q == 8'd0)
  // the not-responding flag only stands with the link down
  `SFC_ASSERT_IMP(a_silent_down, silent_q, link_q == LINK_DOWN)
  // the link state always holds one of its three codes
  `SFC_ASSERT_IMP(a_link_code, 1'b1,
                  link_q == LINK_DOWN || link_q == LINK_DEGRADED || link_q == LINK_OK)

endmodule

// File: hdl/spi_frame_checker_link_monitor.sv
// Top level: input beat register, frame check, link health and result register.
//
// Takes one received byte per beat and accepts a new byte every cycle. Each
// byte is held in an input register, then the byte position, the CRC-16
// update (one byte per cycle through an unrolled eight-bit step) and, on the
// final byte of a frame, the magic/length/CRC checks and link health update
// run together into the result register. A result beat thus appears in the
// result register after the final byte of a frame leaves the input register;
// other bytes give no result. Only a final byte waiting on a full, stalled result
// register holds up the input. Configuration writes are taken every cycle.
module spi_frame_checker_link_monitor #(
  parameter int FRAME_BYTES = 32,
  parameter int CRC_OFFSET  = 30
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  verdict_o,
  output logic [1:0]  link_state_o,
  output logic        not_responding_o,
  output logic [7:0]  message_id_o,
  output logic [7:0]  message_flags_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  bad_run_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sfc_pkg::*;

  `include "spi_frame_checker_link_monitor_defines.svh"

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  logic        s1_go, s1_last, in_accept;
  logic [15:0] magic_q;
  logic [7:0]  limit_q, thresh_q;
  logic        out_valid_q, out_valid_d;
  chk_t        chk;
  health_t     health;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q  <= 16'hA55A;
      limit_q  <= 8'd22;
      thresh_q <= 8'd10;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAGIC_WORD:     magic_q  <= cfg_data_i;
        REG_PAYLOAD_LIMIT:  limit_q  <= cfg_data_i[7:0];
        REG_DOWN_THRESHOLD: thresh_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // process the held byte unless it ends a frame and the result slot is blocked
  assign s1_go      = s1_valid_q && !(s1_last && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  sfc_frame_check #(
    .FRAME_BYTES (FRAME_BYTES),
    .CRC_OFFSET  (CRC_OFFSET)
  ) u_frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (s1_go),
    .byte_i          (s1_byte_q),
    .magic_word_i    (magic_q),
    .payload_limit_i (limit_q),
    .last_o          (s1_last),
    .chk_o           (chk)
  );

  sfc_link_health u_link_health (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .chk_i            (chk),
    .down_threshold_i (thresh_q),
    .health_o         (health)
  );

  // result register: load on frame end, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (chk.done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chk.done) begin
      verdict_o        <= chk.verdict;
      message_id_o     <= chk.message_id;
      message_flags_o  <= chk.message_flags;
      payload_length_o <= chk.payload_length;
      link_state_o     <= health.link_state;
      not_responding_o <= health.not_responding;
      bad_run_o        <= health.bad_run;
    end
  end

  assign out_valid_o = out_valid_q;

  // a processed final byte always lands a result beat
  `SFC_ASSERT_NXT(a_done_gives_result, s1_go && s1_last, out_valid_q)
  // a bad frame never reports message id or flags
  `SFC_ASSERT_IMP(a_bad_no_id, out_valid_q && verdict_o != VERDICT_GOOD,
                  message_id_o == 8'h00 && message_flags_o == 8'h00)
  // a good frame always leaves the link OK with no streak
  `SFC_ASSERT_IMP(a_good_link_ok, out_valid_q && verdict_o == VERDICT_GOOD,
                  link_state_o == LINK_OK && bad_run_o == 8'd0 && !not_responding_o)

endmodule

// File: verif/frame_report_checker.sv
// Frame check and link health predictor that scores the result beats of the frame checker.
package sfc_tb_pkg;

  import sfc_pkg::*;

  localparam int FRAME_LEN = 32;
  localparam int CRC_POS   = 30;

  // one result beat as the block reports it
  typedef struct packed {
    logic [1:0] verdict;
    logic [1:0] link_state;
    logic       not_responding;
    logic [7:0] message_id;
    logic [7:0] message_flags;
    logic [7:0] payload_length;
    logic [7:0] bad_run;
  } frame_report_t;

  // advance CRC-16/CCITT-FALSE by one byte, one data bit at a time
  function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ data[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

module frame_report_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        res_valid_i,
  input  logic        res_stall_i,
  input  logic [1:0]  verdict_i,
  input  logic [1:0]  link_state_i,
  input  logic        not_responding_i,
  input  logic [7:0]  message_id_i,
  input  logic [7:0]  message_flags_i,
  input  logic [7:0]  payload_length_i,
  input  logic [7:0]  bad_run_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  import sfc_pkg::*;
  import sfc_tb_pkg::*;

  // predicted block state
  logic [15:0] cfg_magic;
  logic [7:0]  cfg_limit;
  logic [7:0]  cfg_threshold;
  logic [4:0]  byte_count;
  logic [15:0] crc_acc;
  logic [7:0]  header_q [HDR_COUNT];
  logic [15:0] crc_field;
  logic [7:0]  run_count;
  logic [1:0]  link_q;
  logic        silent_q;

  frame_report_t expected_reports [$];
  int unsigned   mismatches;
  int unsigned   reports_seen;

  // fold one accepted byte into the frame; on the last byte judge it and queue the report
  task automatic predict_rx_byte(input logic [7:0] data);
    frame_report_t rep;
    logic [1:0]    verdict;
    int            pos;
    pos = byte_count;
    if (pos == 0) crc_field = 16'h0000;
    if (pos < HDR_COUNT) header_q[3'(pos)] = data;
    if (pos < CRC_POS) crc_acc = crc16_ccitt_step(crc_acc, data);
    if (pos == CRC_POS) begin
      crc_field[7:0] = data;
    end else if (pos == CRC_POS + 1) begin
      crc_field[15:8] = data;
    end
    if (pos + 1 < FRAME_LEN) begin
      byte_count = 5'(pos + 1);
      return;
    end

    // checks in priority order: sync word, length, CRC
    if ({header_q[1], header_q[0]} != cfg_magic) begin
      verdict = VERDICT_MAGIC;
    end else if (header_q[6] > cfg_limit) begin
      verdict = VERDICT_LENGTH;
    end else if (crc_field != crc_acc) begin
      verdict = VERDICT_CRC;
    end else begin
      verdict = VERDICT_GOOD;
    end

    // link health
    if (verdict == VERDICT_GOOD) begin
      run_count = 8'd0;
      silent_q  = 1'b0;
      link_q    = LINK_OK;
    end else begin
      if (run_count != 8'hFF) run_count = run_count + 8'd1;
      if (run_count >= cfg_threshold) begin
        link_q   = LINK_DOWN;
        silent_q = 1'b1;
      end else if (link_q == LINK_OK) begin
        link_q = LINK_DEGRADED;
      end
    end

    rep.verdict        = verdict;
    rep.link_state     = link_q;
    rep.not_responding = silent_q;
    rep.message_id     = (verdict == VERDICT_GOOD) ? header_q[4] : 8'h00;
    rep.message_flags  = (verdict == VERDICT_GOOD) ? header_q[5] : 8'h00;
    rep.payload_length = header_q[6];
    rep.bad_run        = run_count;
    expected_reports.push_back(rep);

    byte_count = 5'd0;
    crc_acc    = CRC_INIT;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t got;
    frame_report_t exp;
    if (!rst_ni) begin
      cfg_magic     = 16'hA55A;
      cfg_limit     = 8'd22;
      cfg_threshold = 8'd10;
      byte_count    = 5'd0;
      crc_acc       = CRC_INIT;
      crc_field     = 16'h0000;
      run_count     = 8'd0;
      link_q        = LINK_DOWN;
      silent_q      = 1'b0;
      mismatches    = 0;
      reports_seen  = 0;
      expected_reports.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAGIC_WORD:     cfg_magic     = cfg_data_i;
          REG_PAYLOAD_LIMIT:  cfg_limit     = cfg_data_i[7:0];
          REG_DOWN_THRESHOLD: cfg_threshold = cfg_data_i[7:0];
          default: ;
        endcase
      end

      // input beat
      if (byte_valid_i && !byte_stall_i) predict_rx_byte(rx_byte_i);

      // result beat against the oldest expectation
      if (res_valid_i && !res_stall_i) begin
        got.verdict        = verdict_i;
        got.link_state     = link_state_i;
        got.not_responding = not_responding_i;
        got.message_id     = message_id_i;
        got.message_flags  = message_flags_i;
        got.payload_length = payload_length_i;
        got.bad_run        = bad_run_i;
        reports_seen++;
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with no frame outstanding: v=%0d link=%0d",
                     reports_seen, got.verdict, got.link_state);
        end else begin
          exp = expected_reports.pop_front();
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", reports_seen);
              $display("  expected v=%0d link=%0d nr=%0d id=%02h flags=%02h len=%02h run=%0d",
                       exp.verdict, exp.link_state, exp.not_responding, exp.message_id,
                       exp.message_flags, exp.payload_length, exp.bad_run);
              $display("  actual   v=%0d link=%0d nr=%0d id=%02h flags=%02h len=%02h run=%0d",
                       got.verdict, got.link_state, got.not_responding, got.message_id,
                       got.message_flags, got.payload_length, got.bad_run);
            end
          end
        end
      end

      pending_o    <= expected_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// File: verif/spi_frame_checker_link_monitor_tb.sv
// Stimulus, idling and final verdict for the frame checker and link monitor.
module spi_frame_checker_link_monitor_tb;

  import sfc_pkg::*;
  import sfc_tb_pkg::*;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_MAGIC,
    FRAME_BAD_LENGTH,
    FRAME_BAD_CRC,
    FRAME_NOISE
  } frame_kind_e;

  localparam int HOLD_CYCLES = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  verdict_o;
  logic [1:0]  link_state_o;
  logic        not_responding_o;
  logic [7:0]  message_id_o;
  logic [7:0]  message_flags_o;
  logic [7:0]  payload_length_o;
  logic [7:0]  bad_run_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_MAGIC_WORD;
  logic [15:0] cfg_data_i = 16'h0000;

  int unsigned pending_results;
  int unsigned check_failures;

  // register values as the sender knows them, reset values first
  logic [15:0] magic_now = 16'hA55A;
  logic [7:0]  limit_now = 8'd22;

  int idle_pct  = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;
  int   hold_count = 0;

  spi_frame_checker_link_monitor #(
    .FRAME_BYTES(FRAME_LEN),
    .CRC_OFFSET (CRC_POS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .verdict_o       (verdict_o),
    .link_state_o    (link_state_o),
    .not_responding_o(not_responding_o),
    .message_id_o    (message_id_o),
    .message_flags_o (message_flags_o),
    .payload_length_o(payload_length_o),
    .bad_run_o       (bad_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  frame_report_checker verdict_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_valid_i    (in_valid_i),
    .byte_stall_i    (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_i     (out_valid_o),
    .res_stall_i     (out_stall_i),
    .verdict_i       (verdict_o),
    .link_state_i    (link_state_o),
    .not_responding_i(not_responding_o),
    .message_id_i    (message_id_o),
    .message_flags_i (message_flags_o),
    .payload_length_i(payload_length_o),
    .bad_run_i       (bad_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending_results),
    .fail_count_o    (check_failures)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: one long hold-off when asked, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // offer one byte, hold it through stalls, then maybe go idle
  task automatic send_byte(input logic [7:0] data);
    in_valid_i <= 1'b1;
    rx_byte_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // build one frame of the given kind; fill < 0 means random filler, len_req < 0 picks a length
  task automatic send_frame(input frame_kind_e kind, input int fill, input int len_req);
    logic [7:0]  fb [FRAME_LEN];
    logic [15:0] crc;
    frame_kind_e k;
    k = kind;
    // no length byte exceeds a limit of 255
    if (k == FRAME_BAD_LENGTH && limit_now == 8'hFF) k = FRAME_BAD_CRC;
    for (int i = 0; i < FRAME_LEN; i++) fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (k != FRAME_NOISE) begin
      {fb[1], fb[0]} = magic_now;
      if (k == FRAME_BAD_MAGIC) {fb[1], fb[0]} = magic_now ^ 16'($urandom_range(1, 65535));
      if (len_req >= 0) begin
        fb[6] = 8'(len_req);
      end else if (k == FRAME_BAD_LENGTH) begin
        fb[6] = ($urandom_range(3) == 0) ? 8'(int'(limit_now) + 1)
                                         : 8'($urandom_range(int'(limit_now) + 1, 255));
      end else if (k != FRAME_BAD_MAGIC) begin
        fb[6] = ($urandom_range(3) == 0) ? limit_now : 8'($urandom_range(0, int'(limit_now)));
      end
      crc = CRC_INIT;
      for (int i = 0; i < CRC_POS; i++) crc = crc16_ccitt_step(crc, fb[i]);
      // length errors also carry a bad CRC to show the length check wins
      if (k == FRAME_BAD_CRC || k == FRAME_BAD_LENGTH) crc ^= 16'($urandom_range(1, 65535));
      fb[CRC_POS]     = crc[7:0];
      fb[CRC_POS + 1] = crc[15:8];
    end
    for (int i = 0; i < FRAME_LEN; i++) send_byte(fb[i]);
  endtask

  // stop offering and wait until every frame has reported, then let the pipe settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // write all three registers back to back; upper data bits of byte registers are junk
  task automatic apply_settings(input logic [15:0] magic, input logic [7:0] limit,
                                input logic [7:0] thresh);
    write_reg(REG_MAGIC_WORD, magic);
    write_reg(REG_PAYLOAD_LIMIT, {8'($urandom), limit});
    write_reg(REG_DOWN_THRESHOLD, {8'($urandom), thresh});
    cfg_valid_i <= 1'b0;
    magic_now = magic;
    limit_now = limit;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 75; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 75; end
      default: begin idle_pct = 37; stall_pct <= 37; end
    endcase
  endtask

  initial begin
    frame_kind_e kind;
    int          pick;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames at reset settings
    send_frame(FRAME_GOOD, 8'h00, 0);
    send_frame(FRAME_GOOD, 8'hFF, int'(limit_now));
    send_frame(FRAME_BAD_LENGTH, -1, int'(limit_now) + 1);
    send_frame(FRAME_BAD_MAGIC, 8'hFF, 255);
    send_frame(FRAME_BAD_CRC, -1, -1);
    send_frame(FRAME_NOISE, -1, -1);
    send_frame(FRAME_GOOD, -1, -1);
    drain_results();

    // random phases, each with its own settings and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(16'h0000, 8'h00, 8'd1);
        1: apply_settings(16'hFFFF, 8'hFF, 8'hFF);
        2: apply_settings(16'($urandom), 8'($urandom), 8'h00);
        default: apply_settings(16'($urandom), 8'($urandom), 8'($urandom_range(1, 6)));
      endcase
      set_idling(ph % 4);
      // long receiver hold-off while bytes keep coming
      if (ph == 0) hold_req <= 1'b1;
      for (int f = 0; f < 5; f++) begin
        // pause the sender mid-phase until all results are in
        if (ph == 2 && f == 3) drain_results();
        pick = $urandom_range(99);
        if (pick < 40)      kind = FRAME_GOOD;
        else if (pick < 55) kind = FRAME_BAD_MAGIC;
        else if (pick < 70) kind = FRAME_BAD_LENGTH;
        else if (pick < 85) kind = FRAME_BAD_CRC;
        else                kind = FRAME_NOISE;
        send_frame(kind, -1, -1);
      end
      drain_results();
    end

    // take the link down with a bad streak past the threshold, then recover
    apply_settings(16'($urandom), 8'($urandom), 8'd3);
    set_idling(3);
    repeat (4) send_frame(FRAME_BAD_MAGIC, -1, -1);
    send_frame(FRAME_GOOD, -1, -1);
    drain_results();
    repeat (8) @(posedge clk_i);

    if (check_failures == 0 && pending_results == 0) begin
      $display("spi_frame_checker_link_monitor_tb OK");
    end else begin
      $display("spi_frame_checker_link_monitor_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("spi_frame_checker_link_monitor_tb NOT OK");
    $finish;
  end

endmodule
